// ===== hdl/jsys_pkg.sv =====
`timescale 1ns / 1ps
// Package for the jog setpoint yaw stepper: widths, fixed-point constants,
// command codes, CORDIC request types and the arctangent table.
// No dependencies.
package jsys_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);

  localparam int KEY_W   = 8;
  localparam int STEP_W  = 21;
  localparam int YSTEP_W = 15;
  localparam int CFG_W   = 21;
  localparam int POS_W   = 32;
  localparam int Q_W     = 16;
  localparam int XY_W    = 40;
  localparam int Z_W     = 30;
  localparam int ACC_W   = 36;
  localparam int SP_W    = 30;
  localparam int A13_W   = 18;
  localparam int TRIG_W  = 32;
  localparam int ROOT_W  = 29;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 3;

  localparam logic signed [Z_W-1:0]   ANG_PI      = 30'sd52707179;
  localparam logic signed [Z_W-1:0]   ANG_HALF_PI = 30'sd26353589;
  localparam logic signed [XY_W-1:0]  CORDIC_K    = 40'sd652032874;
  localparam logic signed [ACC_W-1:0] ONE_Q28     = 36'sd268435456;
  localparam logic [RAD_W-1:0]        ONE_Q56     = RAD_W'(64'h0100_0000_0000_0000);

  localparam logic [STEP_W-1:0]  POS_STEP_RST = 21'd13107;
  localparam logic [YSTEP_W-1:0] YAW_STEP_RST = 15'd1638;
  localparam logic signed [POS_W-1:0] TARGET_Z_RST = 32'sd65536;

  localparam logic CFG_POS_STEP = 1'b0;
  localparam logic CFG_YAW_STEP = 1'b1;

  localparam logic [KEY_W-1:0] KEY_1 = 8'h31;
  localparam logic [KEY_W-1:0] KEY_2 = 8'h32;
  localparam logic [KEY_W-1:0] KEY_3 = 8'h33;
  localparam logic [KEY_W-1:0] KEY_4 = 8'h34;
  localparam logic [KEY_W-1:0] KEY_5 = 8'h35;
  localparam logic [KEY_W-1:0] KEY_6 = 8'h36;
  localparam logic [KEY_W-1:0] KEY_7 = 8'h37;
  localparam logic [KEY_W-1:0] KEY_8 = 8'h38;
  localparam logic [KEY_W-1:0] KEY_9 = 8'h39;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_Y_UP,
    CMD_Y_DN,
    CMD_X_UP,
    CMD_X_DN,
    CMD_Z_UP,
    CMD_Z_DN,
    CMD_YAW_L,
    CMD_YAW_R,
    CMD_HOLD
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic                    start;
    logic                    vec;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cordic_rsp_t;

  function automatic cmd_t key_to_cmd(logic [KEY_W-1:0] key);
    case (key)
      KEY_1:   return CMD_Y_UP;
      KEY_3:   return CMD_Y_DN;
      KEY_4:   return CMD_X_UP;
      KEY_6:   return CMD_X_DN;
      KEY_8:   return CMD_Z_UP;
      KEY_2:   return CMD_Z_DN;
      KEY_7:   return CMD_YAW_L;
      KEY_9:   return CMD_YAW_R;
      KEY_5:   return CMD_HOLD;
      default: return CMD_NONE;
    endcase
  endfunction

  function automatic logic [23:0] atan_q24(logic [4:0] i);
    case (i)
      5'd0:    return 24'd13176795;
      5'd1:    return 24'd7778716;
      5'd2:    return 24'd4110060;
      5'd3:    return 24'd2086331;
      5'd4:    return 24'd1047214;
      5'd5:    return 24'd524117;
      5'd6:    return 24'd262123;
      5'd7:    return 24'd131069;
      5'd8:    return 24'd65536;
      5'd9:    return 24'd32768;
      5'd10:   return 24'd16384;
      5'd11:   return 24'd8192;
      5'd12:   return 24'd4096;
      5'd13:   return 24'd2048;
      5'd14:   return 24'd1024;
      5'd15:   return 24'd512;
      5'd16:   return 24'd256;
      5'd17:   return 24'd128;
      5'd18:   return 24'd64;
      5'd19:   return 24'd32;
      5'd20:   return 24'd16;
      5'd21:   return 24'd8;
      5'd22:   return 24'd4;
      5'd23:   return 24'd2;
      default: return 24'd0;
    endcase
  endfunction

endpackage

// ===== hdl/jsys_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts key transfers, decodes them into commands and holds
// them in a two-entry queue for the back end. Depends on jsys_pkg.
module jsys_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [jsys_pkg::KEY_W-1:0]    in_key_code,
  output jsys_pkg::q_head_t             q_head,
  input  logic                          q_pop
);

  jsys_pkg::cmd_t mem_r [2];
  logic           wptr_r;
  logic           rptr_r;
  logic [1:0]     cnt_r;
  logic           push;
  logic           pop;

  assign in_stall     = (cnt_r == 2'd2);
  assign push         = in_valid && !in_stall;
  assign pop          = q_pop && (cnt_r != 2'd0);
  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= jsys_pkg::key_to_cmd(in_key_code);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/jsys_isqrt.sv =====
`timescale 1ns / 1ps
// Bit-serial integer square root, one result bit per cycle.
// Depends on jsys_pkg.
module jsys_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [jsys_pkg::RAD_W-1:0]     radicand,
  output logic                           done,
  output logic [jsys_pkg::ROOT_W-1:0]    root
);

  logic [jsys_pkg::RAD_W-1:0]  rad_r;
  logic [jsys_pkg::REM_W-1:0]  rem_r;
  logic [jsys_pkg::ROOT_W-1:0] root_r;
  logic [4:0]                  cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [jsys_pkg::REM_W-1:0]  rem2;
  logic [jsys_pkg::REM_W-1:0]  trial;

  assign rem2  = {rem_r[jsys_pkg::REM_W-3:0], rad_r[jsys_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign done  = done_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= 5'(jsys_pkg::ROOT_W - 1);
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      cnt_r <= cnt_r - 5'd1;
      if (rem2 >= trial) begin
        rem_r  <= rem2 - trial;
        root_r <= {root_r[jsys_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem2;
        root_r <= {root_r[jsys_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == 5'd0)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/jsys_cordic.sv =====
`timescale 1ns / 1ps
// Shared iterative CORDIC, one micro-rotation per cycle, in vectoring mode
// for atan2 and rotation mode for sine and cosine. Depends on jsys_pkg.
module jsys_cordic (
  input  logic                  clk,
  input  logic                  rst_n,
  input  jsys_pkg::cordic_req_t req,
  output jsys_pkg::cordic_rsp_t rsp
);

  logic signed [jsys_pkg::XY_W-1:0] x_r, y_r, x0, y0, dx, dy;
  logic signed [jsys_pkg::Z_W-1:0]  z_r, z0, at;
  logic [jsys_pkg::CNT_W-1:0]       cnt_r;
  logic busy_r, vec_r, flip_r, zero_r, done_r;
  logic flip0, zero0, plus, last;

  always_comb begin
    x0    = req.x;
    y0    = req.y;
    z0    = '0;
    flip0 = 1'b0;
    zero0 = 1'b0;
    if (req.vec) begin
      zero0 = (req.x == '0) && (req.y == '0);
      if (req.x < 0) begin
        z0 = (req.y >= 0) ? jsys_pkg::ANG_PI : -jsys_pkg::ANG_PI;
        x0 = -req.x;
        y0 = -req.y;
      end
    end else begin
      x0 = jsys_pkg::CORDIC_K;
      y0 = '0;
      z0 = req.z;
      if (req.z > jsys_pkg::ANG_HALF_PI) begin
        z0    = req.z - jsys_pkg::ANG_PI;
        flip0 = 1'b1;
      end else if (req.z < -jsys_pkg::ANG_HALF_PI) begin
        z0    = req.z + jsys_pkg::ANG_PI;
        flip0 = 1'b1;
      end
    end
  end

  assign dx   = x_r >>> cnt_r;
  assign dy   = y_r >>> cnt_r;
  assign at   = jsys_pkg::Z_W'(jsys_pkg::atan_q24(5'(cnt_r)));
  assign plus = vec_r ? (y_r > 0) : (z_r < 0);
  assign last = (cnt_r == jsys_pkg::CNT_W'(jsys_pkg::CORDIC_STEPS - 1));

  assign rsp.done = done_r;
  assign rsp.x    = flip_r ? -x_r : x_r;
  assign rsp.y    = flip_r ? -y_r : y_r;
  assign rsp.z    = zero_r ? '0 : z_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= x0;
      y_r    <= y0;
      z_r    <= z0;
      cnt_r  <= '0;
      vec_r  <= req.vec;
      flip_r <= flip0;
      zero_r <= zero0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (plus) begin
        x_r <= x_r + dy;
        y_r <= y_r - dx;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - dy;
        y_r <= y_r + dx;
        z_r <= z_r - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/jsys_back.sv =====
`timescale 1ns / 1ps
// Back end: holds the pose and the step registers, carries out queued
// commands with a shared multiplier, the square root and the CORDIC unit,
// and drives the result register. Depends on jsys_pkg, jsys_isqrt, jsys_cordic.
module jsys_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [jsys_pkg::CFG_W-1:0]          cfg_data,
  input  jsys_pkg::q_head_t                   q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_recognized,
  output logic signed [jsys_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [jsys_pkg::POS_W-1:0]   out_pos_y,
  output logic signed [jsys_pkg::POS_W-1:0]   out_pos_z,
  output logic signed [jsys_pkg::Q_W-1:0]     out_quat_x,
  output logic signed [jsys_pkg::Q_W-1:0]     out_quat_y,
  output logic signed [jsys_pkg::Q_W-1:0]     out_quat_z,
  output logic signed [jsys_pkg::Q_W-1:0]     out_quat_w
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_POS  = 14'b00000000000010,
    S_QM   = 14'b00000000000100,
    S_QA   = 14'b00000000001000,
    S_FIX  = 14'b00000000010000,
    S_SQM  = 14'b00000000100000,
    S_SQS  = 14'b00000001000000,
    S_SQW  = 14'b00000010000000,
    S_CS   = 14'b00000100000000,
    S_CW   = 14'b00001000000000,
    S_PM   = 14'b00010000000000,
    S_PA   = 14'b00100000000000,
    S_QOUT = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  localparam logic [3:0] IDX_QLAST = 4'd9;
  localparam logic [3:0] IDX_PLAST = 4'd11;
  localparam logic [2:0] JOB_LAST  = 3'd5;

  state_t state_r;
  jsys_pkg::cmd_t cmd_r;
  logic [3:0] idx_r;
  logic [2:0] job_r;

  logic [jsys_pkg::STEP_W-1:0]  pos_step_r;
  logic [jsys_pkg::YSTEP_W-1:0] yaw_step_r;

  logic signed [jsys_pkg::POS_W-1:0] tx_r, ty_r, tz_r;
  logic signed [jsys_pkg::Q_W-1:0]   ox_r, oy_r, oz_r, ow_r;

  logic signed [jsys_pkg::ACC_W-1:0]  ar_r, br_r, ay_r, by_r, spa_r;
  logic signed [jsys_pkg::ACC_W-1:0]  sp2, p36;
  logic signed [jsys_pkg::SP_W-1:0]   sp_r, cpa_r;
  logic signed [jsys_pkg::A13_W-1:0]  roll_r, pitch_r, yaw_r, delta_r;
  logic signed [jsys_pkg::TRIG_W-1:0] cr_r, sr_r, cpt_r, spt_r, cy_r, sy_r;
  logic signed [jsys_pkg::TRIG_W-1:0] cc_r, ss_r, cs_r, sc_r, r30;
  logic signed [63:0] qw_r, qx_r, qy_r, qz_r, prod_r, t30;
  logic signed [31:0] mul_a, mul_b;
  logic signed [jsys_pkg::A13_W-1:0] ang;

  logic out_valid_r, out_rec_r, out_free;
  logic signed [jsys_pkg::POS_W-1:0] opx_r, opy_r, opz_r;
  logic signed [jsys_pkg::Q_W-1:0]   oqx_r, oqy_r, oqz_r, oqw_r;

  logic                          sq_start, sq_done;
  logic [jsys_pkg::RAD_W-1:0]    sq_rad;
  logic [jsys_pkg::ROOT_W-1:0]   sq_root;
  jsys_pkg::cordic_req_t         cor_req;
  jsys_pkg::cordic_rsp_t         cor_rsp;

  function automatic logic signed [jsys_pkg::POS_W-1:0] sat_add(
    logic signed [jsys_pkg::POS_W-1:0] a, logic [jsys_pkg::STEP_W-1:0] s, logic neg);
    logic signed [jsys_pkg::POS_W:0] d;
    logic signed [jsys_pkg::POS_W:0] r;
    d = (jsys_pkg::POS_W+1)'(signed'({1'b0, s}));
    if (neg) d = -d;
    r = (jsys_pkg::POS_W+1)'(a) + d;
    if (r > 33'sd2147483647) return 32'sh7fffffff;
    if (r < -33'sd2147483648) return 32'sh80000000;
    return r[jsys_pkg::POS_W-1:0];
  endfunction

  function automatic logic signed [jsys_pkg::A13_W-1:0] rnd13(
    logic signed [jsys_pkg::Z_W-1:0] z);
    logic signed [jsys_pkg::Z_W:0] t;
    t = (jsys_pkg::Z_W+1)'(z) + (jsys_pkg::Z_W+1)'(1024);
    t = t >>> 11;
    return t[jsys_pkg::A13_W-1:0];
  endfunction

  function automatic logic signed [jsys_pkg::Q_W-1:0] q_round(logic signed [63:0] q);
    logic signed [63:0] t;
    t = (q + 64'sd35184372088832) >>> 46;
    if (t > 64'sd32767) return 16'sh7fff;
    if (t < -64'sd32768) return 16'sh8000;
    return t[jsys_pkg::Q_W-1:0];
  endfunction

  jsys_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  jsys_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .rsp   (cor_rsp)
  );

  assign q_pop    = (state_r == S_IDLE) && q_head.valid;
  assign sq_start = (state_r == S_SQS);
  assign sq_rad   = jsys_pkg::ONE_Q56 - prod_r[jsys_pkg::RAD_W-1:0];
  assign out_free = !out_valid_r || !out_stall;
  assign p36      = prod_r[jsys_pkg::ACC_W-1:0];
  assign sp2      = spa_r <<< 1;
  assign t30      = (prod_r + 64'sd536870912) >>> 30;
  assign r30      = t30[jsys_pkg::TRIG_W-1:0];

  always_comb begin
    case (job_r)
      3'd3:    ang = roll_r;
      3'd4:    ang = pitch_r;
      default: ang = yaw_r;
    endcase
    cor_req.start = (state_r == S_CS);
    cor_req.vec   = (job_r < 3'd3);
    cor_req.z     = jsys_pkg::Z_W'(ang) <<< 10;
    case (job_r)
      3'd0: begin
        cor_req.x = jsys_pkg::XY_W'(br_r);
        cor_req.y = jsys_pkg::XY_W'(ar_r);
      end
      3'd1: begin
        cor_req.x = jsys_pkg::XY_W'(cpa_r);
        cor_req.y = jsys_pkg::XY_W'(sp_r);
      end
      default: begin
        cor_req.x = jsys_pkg::XY_W'(by_r);
        cor_req.y = jsys_pkg::XY_W'(ay_r);
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_QM: begin
        case (idx_r)
          4'd0:    begin mul_a = 32'(ow_r); mul_b = 32'(ox_r); end
          4'd1:    begin mul_a = 32'(oy_r); mul_b = 32'(oz_r); end
          4'd2:    begin mul_a = 32'(ox_r); mul_b = 32'(ox_r); end
          4'd3:    begin mul_a = 32'(oy_r); mul_b = 32'(oy_r); end
          4'd4:    begin mul_a = 32'(ow_r); mul_b = 32'(oz_r); end
          4'd5:    begin mul_a = 32'(ox_r); mul_b = 32'(oy_r); end
          4'd6:    begin mul_a = 32'(oz_r); mul_b = 32'(oz_r); end
          4'd7:    begin mul_a = 32'(oy_r); mul_b = 32'(oy_r); end
          4'd8:    begin mul_a = 32'(ow_r); mul_b = 32'(oy_r); end
          default: begin mul_a = 32'(ox_r); mul_b = 32'(oz_r); end
        endcase
      end
      S_SQM: begin
        mul_a = 32'(sp_r);
        mul_b = 32'(sp_r);
      end
      S_PM: begin
        case (idx_r)
          4'd0:    begin mul_a = cy_r; mul_b = cr_r;  end
          4'd1:    begin mul_a = sy_r; mul_b = sr_r;  end
          4'd2:    begin mul_a = cy_r; mul_b = sr_r;  end
          4'd3:    begin mul_a = sy_r; mul_b = cr_r;  end
          4'd4:    begin mul_a = cc_r; mul_b = cpt_r; end
          4'd5:    begin mul_a = ss_r; mul_b = spt_r; end
          4'd6:    begin mul_a = cs_r; mul_b = cpt_r; end
          4'd7:    begin mul_a = sc_r; mul_b = spt_r; end
          4'd8:    begin mul_a = cc_r; mul_b = spt_r; end
          4'd9:    begin mul_a = ss_r; mul_b = cpt_r; end
          4'd10:   begin mul_a = sc_r; mul_b = cpt_r; end
          default: begin mul_a = cs_r; mul_b = spt_r; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    case (state_r)
      S_IDLE: begin
        cmd_r   <= q_head.cmd;
        idx_r   <= '0;
        ar_r    <= '0;
        br_r    <= '0;
        ay_r    <= '0;
        by_r    <= '0;
        spa_r   <= '0;
        delta_r <= (q_head.cmd == jsys_pkg::CMD_YAW_R) ?
                   -jsys_pkg::A13_W'({1'b0, yaw_step_r}) :
                    jsys_pkg::A13_W'({1'b0, yaw_step_r});
      end
      S_QA: begin
        idx_r <= idx_r + 4'd1;
        case (idx_r)
          4'd0, 4'd1: ar_r  <= ar_r + p36;
          4'd2, 4'd3: br_r  <= br_r + p36;
          4'd4, 4'd5: ay_r  <= ay_r + p36;
          4'd6, 4'd7: by_r  <= by_r + p36;
          4'd8:       spa_r <= spa_r + p36;
          default:    spa_r <= spa_r - p36;
        endcase
      end
      S_FIX: begin
        ar_r <= ar_r <<< 1;
        br_r <= jsys_pkg::ONE_Q28 - (br_r <<< 1);
        ay_r <= ay_r <<< 1;
        by_r <= jsys_pkg::ONE_Q28 - (by_r <<< 1);
        if (sp2 > jsys_pkg::ONE_Q28) begin
          sp_r <= jsys_pkg::SP_W'(jsys_pkg::ONE_Q28);
        end else if (sp2 < -jsys_pkg::ONE_Q28) begin
          sp_r <= jsys_pkg::SP_W'(-jsys_pkg::ONE_Q28);
        end else begin
          sp_r <= sp2[jsys_pkg::SP_W-1:0];
        end
      end
      S_SQW: begin
        cpa_r <= jsys_pkg::SP_W'(sq_root);
        job_r <= '0;
      end
      S_CW: begin
        if (cor_rsp.done) begin
          job_r <= job_r + 3'd1;
          idx_r <= '0;
          qw_r  <= '0;
          qx_r  <= '0;
          qy_r  <= '0;
          qz_r  <= '0;
          case (job_r)
            3'd0: roll_r  <= rnd13(cor_rsp.z);
            3'd1: pitch_r <= rnd13(cor_rsp.z);
            3'd2: yaw_r   <= rnd13(cor_rsp.z) + delta_r;
            3'd3: begin
              cr_r <= cor_rsp.x[jsys_pkg::TRIG_W-1:0];
              sr_r <= cor_rsp.y[jsys_pkg::TRIG_W-1:0];
            end
            3'd4: begin
              cpt_r <= cor_rsp.x[jsys_pkg::TRIG_W-1:0];
              spt_r <= cor_rsp.y[jsys_pkg::TRIG_W-1:0];
            end
            default: begin
              cy_r <= cor_rsp.x[jsys_pkg::TRIG_W-1:0];
              sy_r <= cor_rsp.y[jsys_pkg::TRIG_W-1:0];
            end
          endcase
        end
      end
      S_PA: begin
        idx_r <= idx_r + 4'd1;
        case (idx_r)
          4'd0:       cc_r <= r30;
          4'd1:       ss_r <= r30;
          4'd2:       cs_r <= r30;
          4'd3:       sc_r <= r30;
          4'd4, 4'd5: qw_r <= qw_r + prod_r;
          4'd6:       qx_r <= qx_r + prod_r;
          4'd7:       qx_r <= qx_r - prod_r;
          4'd8, 4'd9: qy_r <= qy_r + prod_r;
          4'd10:      qz_r <= qz_r + prod_r;
          default:    qz_r <= qz_r - prod_r;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pos_step_r <= jsys_pkg::POS_STEP_RST;
      yaw_step_r <= jsys_pkg::YAW_STEP_RST;
      tx_r       <= '0;
      ty_r       <= '0;
      tz_r       <= jsys_pkg::TARGET_Z_RST;
      ox_r       <= '0;
      oy_r       <= '0;
      oz_r       <= '0;
      ow_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          jsys_pkg::CFG_POS_STEP: pos_step_r <= cfg_data;
          default:                yaw_step_r <= cfg_data[jsys_pkg::YSTEP_W-1:0];
        endcase
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_head.valid) begin
            case (q_head.cmd)
              jsys_pkg::CMD_Y_UP, jsys_pkg::CMD_Y_DN, jsys_pkg::CMD_X_UP,
              jsys_pkg::CMD_X_DN, jsys_pkg::CMD_Z_UP, jsys_pkg::CMD_Z_DN:
                state_r <= S_POS;
              jsys_pkg::CMD_YAW_L, jsys_pkg::CMD_YAW_R:
                state_r <= S_QM;
              default:
                state_r <= S_OUT;
            endcase
          end
        end
        S_POS: begin
          case (cmd_r)
            jsys_pkg::CMD_Y_UP: ty_r <= sat_add(ty_r, pos_step_r, 1'b0);
            jsys_pkg::CMD_Y_DN: ty_r <= sat_add(ty_r, pos_step_r, 1'b1);
            jsys_pkg::CMD_X_UP: tx_r <= sat_add(tx_r, pos_step_r, 1'b0);
            jsys_pkg::CMD_X_DN: tx_r <= sat_add(tx_r, pos_step_r, 1'b1);
            jsys_pkg::CMD_Z_UP: tz_r <= sat_add(tz_r, pos_step_r, 1'b0);
            default:            tz_r <= sat_add(tz_r, pos_step_r, 1'b1);
          endcase
          state_r <= S_OUT;
        end
        S_QM:  state_r <= S_QA;
        S_QA:  state_r <= (idx_r == IDX_QLAST) ? S_FIX : S_QM;
        S_FIX: state_r <= S_SQM;
        S_SQM: state_r <= S_SQS;
        S_SQS: state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            state_r <= S_CS;
          end
        end
        S_CS:  state_r <= S_CW;
        S_CW: begin
          if (cor_rsp.done) begin
            state_r <= (job_r == JOB_LAST) ? S_PM : S_CS;
          end
        end
        S_PM:  state_r <= S_PA;
        S_PA:  state_r <= (idx_r == IDX_PLAST) ? S_QOUT : S_PM;
        S_QOUT: begin
          ow_r    <= q_round(qw_r);
          ox_r    <= q_round(qx_r);
          oy_r    <= q_round(qy_r);
          oz_r    <= q_round(qz_r);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_rec_r <= (cmd_r != jsys_pkg::CMD_NONE);
      opx_r     <= tx_r;
      opy_r     <= ty_r;
      opz_r     <= tz_r;
      oqx_r     <= ox_r;
      oqy_r     <= oy_r;
      oqz_r     <= oz_r;
      oqw_r     <= ow_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_recognized = out_rec_r;
  assign out_pos_x      = opx_r;
  assign out_pos_y      = opy_r;
  assign out_pos_z      = opz_r;
  assign out_quat_x     = oqx_r;
  assign out_quat_y     = oqy_r;
  assign out_quat_z     = oqz_r;
  assign out_quat_w     = oqw_r;

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r != S_IDLE)
    else $error("command popped without leaving idle");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result loaded outside the output state");

  a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    cor_rsp.done |-> state_r == S_CW)
    else $error("CORDIC finished while the sequencer was not waiting");

endmodule

// ===== hdl/jog_setpoint_yaw_stepper.sv =====
`timescale 1ns / 1ps
// Top level of the jog setpoint yaw stepper: front end with command queue
// and back end with pose, CORDIC and square root. Depends on jsys_pkg,
// jsys_front and jsys_back.
// Flow: a position key passes through the position update to the result;
// the hold key and unknown keys go straight to the result. A turn key runs
// the quaternion products, the square root, 6 CORDIC runs and the final products.
// Keys are carried out one at a time; the queue takes two more keys meanwhile.
// Reset (rst_n low, synchronous) restores the step registers and the pose.
module jog_setpoint_yaw_stepper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [jsys_pkg::KEY_W-1:0]          in_key_code,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_recognized,
  output logic signed [jsys_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [jsys_pkg::POS_W-1:0]   out_pos_y,
  output logic signed [jsys_pkg::POS_W-1:0]   out_pos_z,
  output logic signed [jsys_pkg::Q_W-1:0]     out_quat_x,
  output logic signed [jsys_pkg::Q_W-1:0]     out_quat_y,
  output logic signed [jsys_pkg::Q_W-1:0]     out_quat_z,
  output logic signed [jsys_pkg::Q_W-1:0]     out_quat_w,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [jsys_pkg::CFG_W-1:0]          cfg_data
);

  jsys_pkg::q_head_t q_head;
  logic              q_pop;

  jsys_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_key_code (in_key_code),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  jsys_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_recognized (out_recognized),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_quat_x     (out_quat_x),
    .out_quat_y     (out_quat_y),
    .out_quat_z     (out_quat_z),
    .out_quat_w     (out_quat_w)
  );

endmodule

// ===== sim/jog_setpoint_yaw_stepper_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for jog_setpoint_yaw_stepper: key stimulus, idle and
// stall phases, register changes and a pose predictor in a scoreboard class.
// Depends on jsys_pkg and the jog_setpoint_yaw_stepper RTL.
module jog_setpoint_yaw_stepper_tb;

  typedef struct {
    logic                              recognized;
    logic signed [jsys_pkg::POS_W-1:0] px, py, pz;
    logic signed [jsys_pkg::Q_W-1:0]   qx, qy, qz, qw;
  } pose_t;

  class pose_scoreboard;
    pose_t        pending_poses[$];
    int           errors;
    longint       pos_step, yaw_step;
    int           tx, ty, tz;
    shortint      ox, oy, oz, ow;
    longint       atan_tab[24];

    function new();
      atan_tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                   131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                   256, 128, 64, 32, 16, 8, 4, 2};
      pos_step = jsys_pkg::POS_STEP_RST;
      yaw_step = jsys_pkg::YAW_STEP_RST;
      tx = 0;
      ty = 0;
      tz = jsys_pkg::TARGET_Z_RST;
      ox = 0;
      oy = 0;
      oz = 0;
      ow = 0;
      errors = 0;
    endfunction

    function void set_register(logic idx, longint val);
      if (idx == jsys_pkg::CFG_POS_STEP) pos_step = val & 64'h1FFFFF;
      else yaw_step = val & 64'h7FFF;
    endfunction

    function longint rnd(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function int sat_pos(int a, longint d);
      longint r;
      r = longint'(a) + d;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return int'(r);
    endfunction

    function shortint sat_q(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return shortint'(v);
    endfunction

    function longint isqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    function longint vec_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? longint'(jsys_pkg::ANG_PI) : -longint'(jsys_pkg::ANG_PI);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < jsys_pkg::CORDIC_STEPS && i < 24; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (y > 0) begin
          x += dy; y -= dx; z += atan_tab[i];
        end else begin
          x -= dy; y += dx; z -= atan_tab[i];
        end
      end
      return z;
    endfunction

    function void rotate(longint z, output longint c, output longint s);
      longint x, y, dx, dy;
      bit flip;
      x = jsys_pkg::CORDIC_K;
      y = 0;
      flip = 0;
      if (z > jsys_pkg::ANG_HALF_PI) begin
        z -= jsys_pkg::ANG_PI; flip = 1;
      end else if (z < -longint'(jsys_pkg::ANG_HALF_PI)) begin
        z += jsys_pkg::ANG_PI; flip = 1;
      end
      for (int i = 0; i < jsys_pkg::CORDIC_STEPS && i < 24; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (z >= 0) begin
          x -= dy; y += dx; z -= atan_tab[i];
        end else begin
          x += dy; y -= dx; z += atan_tab[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = x;
      s = y;
    endfunction

    function void turn_yaw(longint delta);
      longint qx, qy, qz, qw, ar, br, ay, by, sp_arg, cp_arg, one;
      longint roll, pitch, yaw, cr, sr, cp, sp, cy, sy, cc, ss, cs, sc;
      qx = ox; qy = oy; qz = oz; qw = ow;
      one = jsys_pkg::ONE_Q28;
      ar = 2 * (qw * qx + qy * qz);
      br = one - 2 * (qx * qx + qy * qy);
      ay = 2 * (qw * qz + qx * qy);
      by = one - 2 * (qz * qz + qy * qy);
      sp_arg = 2 * (qw * qy - qx * qz);
      if (sp_arg > one) sp_arg = one;
      if (sp_arg < -one) sp_arg = -one;
      cp_arg = isqrt(longint'(one * one - sp_arg * sp_arg));
      roll = rnd(vec_angle(ar, br), 11);
      pitch = rnd(vec_angle(sp_arg, cp_arg), 11);
      yaw = rnd(vec_angle(ay, by), 11) + delta;
      rotate(roll * 1024, cr, sr);
      rotate(pitch * 1024, cp, sp);
      rotate(yaw * 1024, cy, sy);
      cc = rnd(cy * cr, 30);
      ss = rnd(sy * sr, 30);
      cs = rnd(cy * sr, 30);
      sc = rnd(sy * cr, 30);
      ow = sat_q(rnd(cc * cp + ss * sp, 46));
      ox = sat_q(rnd(cs * cp - sc * sp, 46));
      oy = sat_q(rnd(cc * sp + ss * cp, 46));
      oz = sat_q(rnd(sc * cp - cs * sp, 46));
    endfunction

    function void note_key(logic [jsys_pkg::KEY_W-1:0] key);
      pose_t p;
      case (key)
        jsys_pkg::KEY_1: ty = sat_pos(ty, pos_step);
        jsys_pkg::KEY_3: ty = sat_pos(ty, -pos_step);
        jsys_pkg::KEY_4: tx = sat_pos(tx, pos_step);
        jsys_pkg::KEY_6: tx = sat_pos(tx, -pos_step);
        jsys_pkg::KEY_8: tz = sat_pos(tz, pos_step);
        jsys_pkg::KEY_2: tz = sat_pos(tz, -pos_step);
        jsys_pkg::KEY_7: turn_yaw(yaw_step);
        jsys_pkg::KEY_9: turn_yaw(-yaw_step);
        default: ;
      endcase
      p.recognized = (key >= jsys_pkg::KEY_1 && key <= jsys_pkg::KEY_9);
      p.px = tx; p.py = ty; p.pz = tz;
      p.qx = ox; p.qy = oy; p.qz = oz; p.qw = ow;
      pending_poses.push_back(p);
    endfunction

    function void check_pose(pose_t got);
      pose_t e;
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        errors++;
        return;
      end
      e = pending_poses.pop_front();
      if (got.recognized !== e.recognized) begin
        $display("%0t: recognized exp %0d got %0d", $time, e.recognized, got.recognized);
        errors++;
      end
      if (got.px !== e.px) begin
        $display("%0t: pos_x exp %0d got %0d", $time, e.px, got.px); errors++;
      end
      if (got.py !== e.py) begin
        $display("%0t: pos_y exp %0d got %0d", $time, e.py, got.py); errors++;
      end
      if (got.pz !== e.pz) begin
        $display("%0t: pos_z exp %0d got %0d", $time, e.pz, got.pz); errors++;
      end
      if (got.qx !== e.qx) begin
        $display("%0t: quat_x exp %0d got %0d", $time, e.qx, got.qx); errors++;
      end
      if (got.qy !== e.qy) begin
        $display("%0t: quat_y exp %0d got %0d", $time, e.qy, got.qy); errors++;
      end
      if (got.qz !== e.qz) begin
        $display("%0t: quat_z exp %0d got %0d", $time, e.qz, got.qz); errors++;
      end
      if (got.qw !== e.qw) begin
        $display("%0t: quat_w exp %0d got %0d", $time, e.qw, got.qw); errors++;
      end
    endfunction
  endclass

  logic                              clk, rst_n;
  logic                              in_valid, in_stall;
  logic [jsys_pkg::KEY_W-1:0]        in_key_code;
  logic                              out_valid, out_stall, out_recognized;
  logic signed [jsys_pkg::POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [jsys_pkg::Q_W-1:0]   out_quat_x, out_quat_y, out_quat_z, out_quat_w;
  logic                              cfg_we, cfg_index;
  logic [jsys_pkg::CFG_W-1:0]        cfg_data;

  pose_scoreboard sb;
  int             send_pct, recv_pct;
  bit             hold_req;
  int             hold_cnt;
  longint         cycles;

  jog_setpoint_yaw_stepper dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAIL jog_setpoint_yaw_stepper");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) hold_cnt--;
    out_stall <= (hold_cnt > 0) || ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk) begin
    pose_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.recognized = out_recognized;
      got.px = out_pos_x; got.py = out_pos_y; got.pz = out_pos_z;
      got.qx = out_quat_x; got.qy = out_quat_y; got.qz = out_quat_z; got.qw = out_quat_w;
      sb.check_pose(got);
    end
  end

  task automatic send_key(logic [jsys_pkg::KEY_W-1:0] key);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_key_code <= key;
    do @(posedge clk); while (in_stall);
    sb.note_key(key);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_poses.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [jsys_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [jsys_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 15) return jsys_pkg::KEY_W'($urandom_range(255));
    if (r < 45) return ($urandom_range(1) != 0) ? jsys_pkg::KEY_7 : jsys_pkg::KEY_9;
    return jsys_pkg::KEY_1 + jsys_pkg::KEY_W'($urandom_range(8));
  endfunction

  initial begin
    logic [jsys_pkg::KEY_W-1:0] directed[$];
    sb = new();
    cycles = 0;
    rst_n = 0;
    in_valid = 0;
    in_key_code = 0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    send_pct = 0;
    recv_pct = 0;
    hold_req = 0;
    hold_cnt = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    directed = '{8'h00, 8'hFF, 8'h30, 8'h3A, jsys_pkg::KEY_7, jsys_pkg::KEY_1,
                 jsys_pkg::KEY_2, jsys_pkg::KEY_3, jsys_pkg::KEY_4, jsys_pkg::KEY_5,
                 jsys_pkg::KEY_6, jsys_pkg::KEY_8, jsys_pkg::KEY_9, jsys_pkg::KEY_7,
                 jsys_pkg::KEY_7, jsys_pkg::KEY_9, 8'hAA, 8'h55, jsys_pkg::KEY_5,
                 jsys_pkg::KEY_9};
    foreach (directed[i]) send_key(directed[i]);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(jsys_pkg::CFG_POS_STEP, jsys_pkg::POS_STEP_RST);
          write_reg(jsys_pkg::CFG_YAW_STEP, jsys_pkg::CFG_W'(jsys_pkg::YAW_STEP_RST));
        end
        1: begin
          write_reg(jsys_pkg::CFG_POS_STEP, 21'd1048576);
          write_reg(jsys_pkg::CFG_YAW_STEP, 21'd25736);
        end
        2: begin
          write_reg(jsys_pkg::CFG_POS_STEP, 21'd0);
          write_reg(jsys_pkg::CFG_YAW_STEP, 21'd0);
        end
        3: begin
          write_reg(jsys_pkg::CFG_POS_STEP, jsys_pkg::CFG_W'($urandom_range(1048576)));
          write_reg(jsys_pkg::CFG_YAW_STEP, jsys_pkg::CFG_W'($urandom_range(25736)));
        end
        default: begin
          write_reg(jsys_pkg::CFG_POS_STEP, 21'd1);
          write_reg(jsys_pkg::CFG_YAW_STEP, 21'd1);
        end
      endcase
      case (p % 4)
        0: begin send_pct = 0; recv_pct = 0; end
        1: begin send_pct = 82; recv_pct = 0; end
        2: begin send_pct = 0; recv_pct = 82; end
        default: begin send_pct = 15; recv_pct = 15; end
      endcase
      if (p == 0) hold_req = 1;
      for (int i = 0; i < 300; i++) begin
        if (p % 4 == 3 && i % 100 == 50) begin
          send_pct = 0; recv_pct = 0;
        end else if (p % 4 == 3 && i % 100 == 75) begin
          send_pct = 15; recv_pct = 15;
        end
        send_key(pick_key());
      end
      send_pct = 0;
      recv_pct = 0;
      drain();
    end

    if (sb.errors == 0 && sb.pending_poses.size() == 0) begin
      $display("PASS jog_setpoint_yaw_stepper");
    end else begin
      $display("FAIL jog_setpoint_yaw_stepper");
    end
    $finish;
  end
endmodule
